// ----- design/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue: the stored entry
// layout, request opcodes and result status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int DATA_W = 32;
   localparam int PRIO_W = 16;
   localparam int OCC_W  = 5;

   // one stored entry: priority on top, data word below
   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [DATA_W-1:0] data;
   } entry_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

endpackage

// ----- design/sorted_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue held in a sorted circular store.
// ----------------------------------------------------------------------------
// Each request word gives exactly one response word. A remove reads the
// head slot, then latches the entry and advances the head, then loads the
// response register. An insert into an empty queue writes the head slot;
// a refused request goes straight to the response step. Any other insert
// walks from the rear: the store has one write port and a registered read,
// so held entries of lower priority move back one slot per cycle. A new
// request is taken while the previous response still waits.
// Larger priority leaves first; equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic signed [spq_pkg::DATA_W-1:0] req_data_in,
   input  logic [spq_pkg::PRIO_W-1:0]        req_priority_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_out_valid,
   output logic signed [spq_pkg::DATA_W-1:0] rsp_out_data,
   output logic [spq_pkg::PRIO_W-1:0]        rsp_out_priority,
   output logic [spq_pkg::OCC_W-1:0]         rsp_occupancy
);
   import spq_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   entry_type     mem_wr_entry;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   entry_type     mem_rd_entry;

   spq_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_entry (mem_wr_entry),
      .rd_en    (mem_rd_en),
      .rd_addr  (mem_rd_addr),
      .rd_entry (mem_rd_entry)
   );

   spq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_data_in      (req_data_in),
      .req_priority_in  (req_priority_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_data     (rsp_out_data),
      .rsp_out_priority (rsp_out_priority),
      .rsp_occupancy    (rsp_occupancy),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_entry     (mem_wr_entry),
      .mem_rd_en        (mem_rd_en),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_entry     (mem_rd_entry)
   );

endmodule

// ----- design/spq_store.sv -----
// ----------------------------------------------------------------------------
// spq_store
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spq_store #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  spq_pkg::entry_type  wr_entry,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output spq_pkg::entry_type  rd_entry
);
   import spq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ----- design/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spq_ctrl
// Queue sequencer. The store is a circular buffer addressed from a head
// pointer; a remove reads the head and advances it, an insert walks from the
// rear toward the front, moving lower-priority entries back one slot a cycle.
// Also holds the result output register.
// ----------------------------------------------------------------------------
module spq_ctrl #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_opcode,
   input  logic signed [spq_pkg::DATA_W-1:0] req_data_in,
   input  logic [spq_pkg::PRIO_W-1:0]   req_priority_in,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_out_valid,
   output logic signed [spq_pkg::DATA_W-1:0] rsp_out_data,
   output logic [spq_pkg::PRIO_W-1:0]   rsp_out_priority,
   output logic [spq_pkg::OCC_W-1:0]    rsp_occupancy,
   output logic                         mem_wr_en,
   output logic [AW-1:0]                mem_wr_addr,
   output spq_pkg::entry_type           mem_wr_entry,
   output logic                         mem_rd_en,
   output logic [AW-1:0]                mem_rd_addr,
   input  spq_pkg::entry_type           mem_rd_entry
);
   import spq_pkg::*;

   localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_PLACE,
      S_POP,
      S_RESP
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [CW-1:0]      pos_ff, pos_in;
   entry_type          item_ff, item_in;
   status_type         res_status_ff, res_status_in;
   logic               res_valid_ff, res_valid_in;
   entry_type          res_entry_ff, res_entry_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_out_valid_ff, rsp_out_valid_in;
   entry_type          rsp_entry_ff, rsp_entry_in;
   logic [OCC_W-1:0]   rsp_occ_ff, rsp_occ_in;

   // logical position -> physical slot, wrapping at DEPTH
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd,
                                          input logic [CW-1:0] lg);
      logic [AW:0] sum;
      sum = {1'b0, hd} + (AW+1)'(lg);
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[AW-1:0];
   endfunction

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      head_in          = head_ff;
      pos_in           = pos_ff;
      item_in          = item_ff;
      res_status_in    = res_status_ff;
      res_valid_in     = res_valid_ff;
      res_entry_in     = res_entry_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_out_valid_in = rsp_out_valid_ff;
      rsp_entry_in     = rsp_entry_ff;
      rsp_occ_in       = rsp_occ_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      mem_wr_en        = 1'b0;
      mem_wr_addr      = head_ff;
      mem_wr_entry     = item_ff;
      mem_rd_en        = 1'b0;
      mem_rd_addr      = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in.prio  = req_priority_in;
               item_in.data  = req_data_in;
               res_status_in = ST_DONE;
               res_valid_in  = 1'b0;
               res_entry_in  = '0;
               if (opcode_type'(req_opcode) == OP_INSERT) begin
                  if (count_ff == DEPTH_C) begin
                     res_status_in = ST_FULL;
                     state_in      = S_RESP;
                  end else if (count_ff == '0) begin
                     mem_wr_en         = 1'b1;
                     mem_wr_addr       = head_ff;
                     mem_wr_entry.prio = req_priority_in;
                     mem_wr_entry.data = req_data_in;
                     count_in          = count_ff + CW'(1);
                     state_in          = S_RESP;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = phys(head_ff, count_ff - CW'(1));
                     pos_in      = count_ff;
                     state_in    = S_SHIFT;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                     state_in      = S_RESP;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = head_ff;
                     state_in    = S_POP;
                  end
               end
            end
         end
         S_SHIFT: begin
            // read word holds the entry at pos-1
            if (mem_rd_entry.prio < item_ff.prio) begin
               mem_wr_en    = 1'b1;
               mem_wr_addr  = phys(head_ff, pos_ff);
               mem_wr_entry = mem_rd_entry;
               pos_in       = pos_ff - CW'(1);
               if (pos_ff == CW'(1)) begin
                  state_in = S_PLACE;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = phys(head_ff, pos_ff - CW'(2));
               end
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = phys(head_ff, pos_ff);
               count_in    = count_ff + CW'(1);
               state_in    = S_RESP;
            end
         end
         S_PLACE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = phys(head_ff, pos_ff);
            count_in    = count_ff + CW'(1);
            state_in    = S_RESP;
         end
         S_POP: begin
            res_valid_in = 1'b1;
            res_entry_in = mem_rd_entry;
            head_in      = phys(head_ff, CW'(1));
            count_in     = count_ff - CW'(1);
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = res_status_ff;
               rsp_out_valid_in = res_valid_ff;
               rsp_entry_in     = res_entry_ff;
               rsp_occ_in       = OCC_W'(count_ff);
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff           <= pos_in;
      item_ff          <= item_in;
      res_status_ff    <= res_status_in;
      res_valid_ff     <= res_valid_in;
      res_entry_ff     <= res_entry_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_out_valid_ff <= rsp_out_valid_in;
      rsp_entry_ff     <= rsp_entry_in;
      rsp_occ_ff       <= rsp_occ_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_valid    = rsp_out_valid_ff;
   assign rsp_out_data     = rsp_entry_ff.data;
   assign rsp_out_priority = rsp_entry_ff.prio;
   assign rsp_occupancy    = rsp_occ_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above depth");

   a_no_rw_clash : assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr)))
      else $error("read and write hit the same slot");

   a_shift_pos : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (pos_ff != '0))
      else $error("shift walk ran past the front");

   a_pop_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("remove did not drop the count");

endmodule
